@@ rtl/pipc_pkg.sv @@
// Shared types and constants for the point-in-polygon crossing counter.
package pipc_pkg;

  localparam int RAY_END_X = 10000;
  localparam logic signed [31:0] RAY_X_Q = 32'(RAY_END_X * 65536);

  localparam int          CNT_W     = 11;
  localparam logic [10:0] COUNT_MAX = 11'd1024;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int RES_DEPTH = 2;
  localparam int RAW       = $clog2(RES_DEPTH);

  typedef enum logic [0:0] {
    REG_QUERY_X,
    REG_QUERY_Y
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_SKIP,
    CLS_COUNT,
    CLS_TEST
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic               last;
    logic               qge;
    logic               rin;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] qay;
    logic signed [32:0] qax;
    logic signed [32:0] rax;
  } edge_cmd_t;

  typedef struct packed {
    logic             interior;
    logic [CNT_W-1:0] total;
  } res_t;

endpackage

@@ rtl/point_in_polygon_crossing_top.sv @@
// Top level of the point-in-polygon crossing counter.
//
// The query point is set through the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high. Writes must be made while no
// polygon is in flight; the block does not enforce this. Index 0 is query_x and
// index 1 is query_y, both Q16.16. Edges enter through a queue-style port: an
// item is taken when push is high and full is low. One edge is accepted every
// cycle while the edge queue has room. Each edge is classified on entry, queued,
// and then goes through two stages of the back end: three 33 by 33 bit products,
// then the orientation signs and the crossing decision, after which the counter
// is updated. The edge marked last produces one result item; it is written into
// the result queue, shows on the out_ ports with empty low, and leaves on pop. Up
// to two results wait in the result queue; if full with a last edge in stage two,
// the back end holds and the edge queue fills, after which full is raised until
// pop drains it. Reset clears the query point, the count and both queues.
module point_in_polygon_crossing_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic signed [31:0]         in_edge_ax,
  input  logic signed [31:0]         in_edge_ay,
  input  logic signed [31:0]         in_edge_bx,
  input  logic signed [31:0]         in_edge_by,
  input  logic                       in_last_edge,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_inside_res,
  output logic [pipc_pkg::CNT_W-1:0] out_crossing_total
);

  logic signed [31:0]  query_x_r;
  logic signed [31:0]  query_x_nxt;
  logic signed [31:0]  query_y_r;
  logic signed [31:0]  query_y_nxt;
  pipc_pkg::edge_cmd_t front_cmd;
  pipc_pkg::edge_cmd_t q_cmd;
  logic                q_empty;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    query_x_nxt = query_x_r;
    query_y_nxt = query_y_r;
    if (cfg_valid) begin
      case (pipc_pkg::cfg_reg_t'(cfg_index))
        pipc_pkg::REG_QUERY_X: query_x_nxt = cfg_data;
        pipc_pkg::REG_QUERY_Y: query_y_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r <= '0;
      query_y_r <= '0;
    end else begin
      query_x_r <= query_x_nxt;
      query_y_r <= query_y_nxt;
    end
  end

  pipc_front u_front (
    .query_x   (query_x_r),
    .query_y   (query_y_r),
    .edge_ax   (in_edge_ax),
    .edge_ay   (in_edge_ay),
    .edge_bx   (in_edge_bx),
    .edge_by   (in_edge_by),
    .last_edge (in_last_edge),
    .cmd       (front_cmd)
  );

  pipc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (front_cmd),
    .full    (full),
    .pop     (q_pop),
    .cmd_out (q_cmd),
    .empty   (q_empty)
  );

  pipc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .inside_res     (out_inside_res),
    .crossing_total (out_crossing_total)
  );

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("edge queue full after reset");

  a_idle_queue_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_empty && !push) |=> q_empty)
    else $error("edge queue gained an item without a push");

  a_total_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_crossing_total <= pipc_pkg::COUNT_MAX))
    else $error("crossing total beyond its saturation value");

endmodule

@@ rtl/pipc_front.sv @@
// Front end: classifies each incoming edge and prepares the differences for the back end.
module pipc_front (
  input  logic signed [31:0]   query_x,
  input  logic signed [31:0]   query_y,
  input  logic signed [31:0]   edge_ax,
  input  logic signed [31:0]   edge_ay,
  input  logic signed [31:0]   edge_bx,
  input  logic signed [31:0]   edge_by,
  input  logic                 last_edge,
  output pipc_pkg::edge_cmd_t  cmd
);

  logic               skip_box;
  logic               on_a;
  logic               on_b;
  logic               q_at_end;
  logic signed [31:0] min_x;
  logic signed [31:0] max_x;
  pipc_pkg::cls_t     cls;

  always_comb begin
    skip_box = (query_y < edge_ay && query_y < edge_by) ||
               (query_y > edge_ay && query_y > edge_by) ||
               (query_x > edge_ax && query_x > edge_bx);
    q_at_end = (query_x == pipc_pkg::RAY_X_Q);
    on_a     = (edge_ay == query_y) || q_at_end;
    on_b     = (edge_by == query_y) || q_at_end;
    if (skip_box || (on_a && on_b)) begin
      cls = pipc_pkg::CLS_SKIP;
    end else if (on_a) begin
      cls = (edge_by > query_y) ? pipc_pkg::CLS_COUNT : pipc_pkg::CLS_SKIP;
    end else if (on_b) begin
      cls = (edge_ay > query_y) ? pipc_pkg::CLS_COUNT : pipc_pkg::CLS_SKIP;
    end else begin
      cls = pipc_pkg::CLS_TEST;
    end
  end

  always_comb begin
    min_x    = (edge_ax < edge_bx) ? edge_ax : edge_bx;
    max_x    = (edge_ax < edge_bx) ? edge_bx : edge_ax;
    cmd.cls  = cls;
    cmd.last = last_edge;
    cmd.qge  = (query_x >= min_x);
    cmd.rin  = (pipc_pkg::RAY_X_Q >= min_x) && (pipc_pkg::RAY_X_Q <= max_x);
    cmd.dx   = $signed({edge_bx[31], edge_bx}) - $signed({edge_ax[31], edge_ax});
    cmd.dy   = $signed({edge_by[31], edge_by}) - $signed({edge_ay[31], edge_ay});
    cmd.qay  = $signed({query_y[31], query_y}) - $signed({edge_ay[31], edge_ay});
    cmd.qax  = $signed({query_x[31], query_x}) - $signed({edge_ax[31], edge_ax});
    cmd.rax  = $signed({pipc_pkg::RAY_X_Q[31], pipc_pkg::RAY_X_Q}) -
               $signed({edge_ax[31], edge_ax});
  end

endmodule

@@ rtl/pipc_queue.sv @@
// Short edge queue that decouples the front end from the back end.
module pipc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pipc_pkg::edge_cmd_t cmd_in,
  output logic                full,
  input  logic                pop,
  output pipc_pkg::edge_cmd_t cmd_out,
  output logic                empty
);

  pipc_pkg::edge_cmd_t           mem_r [pipc_pkg::QDEPTH];
  logic [pipc_pkg::QAW-1:0]      wr_r;
  logic [pipc_pkg::QAW-1:0]      wr_nxt;
  logic [pipc_pkg::QAW-1:0]      rd_r;
  logic [pipc_pkg::QAW-1:0]      rd_nxt;
  logic [pipc_pkg::QAW:0]        cnt_r;
  logic [pipc_pkg::QAW:0]        cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  always_comb begin
    full    = (cnt_r == (pipc_pkg::QAW+1)'(pipc_pkg::QDEPTH));
    empty   = (cnt_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    cmd_out = mem_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= cmd_in;
    end
  end

endmodule

@@ rtl/pipc_back.sv @@
// Back end: orientation products, crossing decision, counter and result queue.
module pipc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  pipc_pkg::edge_cmd_t            q_cmd,
  output logic                           q_pop,
  output logic                           empty,
  input  logic                           pop,
  output logic                           inside_res,
  output logic [pipc_pkg::CNT_W-1:0]     crossing_total
);

  logic                          adv;

  logic                          s1_v_r;
  logic                          s1_v_nxt;
  pipc_pkg::cls_t                s1_cls_r;
  pipc_pkg::cls_t                s1_cls_nxt;
  logic                          s1_last_r;
  logic                          s1_last_nxt;
  logic                          s1_qge_r;
  logic                          s1_qge_nxt;
  logic                          s1_rin_r;
  logic                          s1_rin_nxt;
  logic signed [65:0]            p0_r;
  logic signed [65:0]            p0_nxt;
  logic signed [65:0]            p1_r;
  logic signed [65:0]            p1_nxt;
  logic signed [65:0]            p2_r;
  logic signed [65:0]            p2_nxt;

  logic signed [66:0]            o3;
  logic signed [66:0]            o4;
  logic                          z3;
  logic                          z4;
  logic                          hit;

  logic                          s2_v_r;
  logic                          s2_v_nxt;
  logic                          s2_hit_r;
  logic                          s2_hit_nxt;
  logic                          s2_last_r;
  logic                          s2_last_nxt;

  logic [pipc_pkg::CNT_W-1:0]    cnt_r;
  logic [pipc_pkg::CNT_W-1:0]    cnt_nxt;
  logic                          par_r;
  logic                          par_nxt;
  logic [pipc_pkg::CNT_W-1:0]    cnt_new;
  logic                          par_new;

  pipc_pkg::res_t                res_mem_r [pipc_pkg::RES_DEPTH];
  logic [pipc_pkg::RAW-1:0]      res_wr_r;
  logic [pipc_pkg::RAW-1:0]      res_wr_nxt;
  logic [pipc_pkg::RAW-1:0]      res_rd_r;
  logic [pipc_pkg::RAW-1:0]      res_rd_nxt;
  logic [pipc_pkg::RAW:0]        res_cnt_r;
  logic [pipc_pkg::RAW:0]        res_cnt_nxt;
  logic                          res_full;
  logic                          res_push;
  logic                          res_pop;
  pipc_pkg::res_t                res_in;

  always_comb begin
    res_full = (res_cnt_r == (pipc_pkg::RAW+1)'(pipc_pkg::RES_DEPTH));
    adv      = !(s2_v_r && s2_last_r && res_full);
    q_pop    = adv && !q_empty;
  end

  always_comb begin
    s1_v_nxt    = adv ? !q_empty : s1_v_r;
    s1_cls_nxt  = adv ? q_cmd.cls : s1_cls_r;
    s1_last_nxt = adv ? q_cmd.last : s1_last_r;
    s1_qge_nxt  = adv ? q_cmd.qge : s1_qge_r;
    s1_rin_nxt  = adv ? q_cmd.rin : s1_rin_r;
    p0_nxt      = adv ? q_cmd.dx * q_cmd.qay : p0_r;
    p1_nxt      = adv ? q_cmd.dy * q_cmd.qax : p1_r;
    p2_nxt      = adv ? q_cmd.dy * q_cmd.rax : p2_r;
  end

  always_comb begin
    o3 = 67'(p0_r) - 67'(p1_r);
    o4 = 67'(p0_r) - 67'(p2_r);
    z3 = (o3 == '0);
    z4 = (o4 == '0);
    case (s1_cls_r)
      pipc_pkg::CLS_COUNT: hit = 1'b1;
      pipc_pkg::CLS_TEST:  hit = (o3[66] != o4[66]) || (z3 != z4) ||
                                 (z3 && s1_qge_r) || (z4 && s1_rin_r);
      default:             hit = 1'b0;
    endcase
    s2_v_nxt    = adv ? s1_v_r : s2_v_r;
    s2_hit_nxt  = adv ? hit : s2_hit_r;
    s2_last_nxt = adv ? s1_last_r : s2_last_r;
  end

  always_comb begin
    cnt_new = cnt_r;
    par_new = par_r;
    if (s2_hit_r) begin
      par_new = !par_r;
      if (cnt_r != pipc_pkg::COUNT_MAX) begin
        cnt_new = cnt_r + 1'b1;
      end
    end
    res_push        = s2_v_r && s2_last_r && adv;
    res_in.interior = par_new;
    res_in.total    = cnt_new;
    cnt_nxt = cnt_r;
    par_nxt = par_r;
    if (s2_v_r && adv) begin
      cnt_nxt = s2_last_r ? '0 : cnt_new;
      par_nxt = s2_last_r ? 1'b0 : par_new;
    end
  end

  always_comb begin
    empty       = (res_cnt_r == '0);
    res_pop     = pop && !empty;
    res_wr_nxt  = res_push ? res_wr_r + 1'b1 : res_wr_r;
    res_rd_nxt  = res_pop ? res_rd_r + 1'b1 : res_rd_r;
    res_cnt_nxt = res_cnt_r;
    if (res_push && !res_pop) begin
      res_cnt_nxt = res_cnt_r + 1'b1;
    end else if (res_pop && !res_push) begin
      res_cnt_nxt = res_cnt_r - 1'b1;
    end
    inside_res     = res_mem_r[res_rd_r].interior;
    crossing_total = res_mem_r[res_rd_r].total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      cnt_r     <= '0;
      par_r     <= 1'b0;
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
      cnt_r     <= cnt_nxt;
      par_r     <= par_nxt;
      res_wr_r  <= res_wr_nxt;
      res_rd_r  <= res_rd_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cls_r  <= s1_cls_nxt;
    s1_last_r <= s1_last_nxt;
    s1_qge_r  <= s1_qge_nxt;
    s1_rin_r  <= s1_rin_nxt;
    p0_r      <= p0_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    s2_hit_r  <= s2_hit_nxt;
    s2_last_r <= s2_last_nxt;
    if (res_push) begin
      res_mem_r[res_wr_r] <= res_in;
    end
  end

endmodule
